### src/arc_pkg.sv
// arc_pkg: shared types, codes and widths of the arp resolution cache
// no dependencies; used by arc_table, arc_ctrl and arp_resolution_cache_unit

package arc_pkg;

  localparam int DEPTH_DEFAULT = 32;

  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int HW_W     = 16;
  localparam int OP_W     = 16;
  localparam int CLIENT_W = 8;
  localparam int IF_W     = 8;

  localparam logic [OP_W-1:0]  OP_REQUEST = 16'd1;
  localparam logic [OP_W-1:0]  OP_REPLY   = 16'd2;
  localparam logic [MAC_W-1:0] MAC_BCAST  = '1;
  localparam logic [HW_W-1:0]  HW_PENDING = '1;

  typedef enum logic {
    CMD_PACKET = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_REPLY = 3'd0,
    KIND_BCAST = 3'd1,
    KIND_HIT   = 3'd2,
    KIND_WAIT  = 3'd3,
    KIND_FULL  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_OWN_IP      = 2'd0,
    REG_OWN_MAC     = 2'd1,
    REG_OWN_IF      = 2'd2,
    REG_PROTOCOL_ID = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ACT
  } state_t;

  // input word, last field in the lowest bits
  typedef struct packed {
    logic [CLIENT_W-1:0] requester_id;
    logic [IP_W-1:0]     query_ip;
    logic [IP_W-1:0]     target_ip;
    logic [MAC_W-1:0]    sender_mac;
    logic [IP_W-1:0]     sender_ip;
    logic [HW_W-1:0]     hw_type;
    logic [OP_W-1:0]     arp_ident;
    logic [OP_W-1:0]     arp_op;
  } in_item_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [IF_W-1:0]     peer_if_index;
    logic [HW_W-1:0]     peer_hw_type;
    logic [MAC_W-1:0]    peer_mac;
    logic [IP_W-1:0]     peer_ip;
    logic [CLIENT_W-1:0] client_id;
  } out_item_t;

  typedef struct packed {
    kind_t     kind;
    out_item_t item;
  } res_t;

  typedef struct packed {
    logic [IP_W-1:0]     ip;
    logic [MAC_W-1:0]    mac;
    logic [HW_W-1:0]     hw_kind;
    logic                resolved;
    logic                waiting;
    logic [CLIENT_W-1:0] client;
  } entry_t;

  typedef struct packed {
    logic [IP_W-1:0] own_ip;
    logic [IF_W-1:0] own_if_index;
    logic [OP_W-1:0] protocol_id;
  } cfg_t;

endpackage

### src/arc_table.sv
// arc_table: entry store of the cache, one write and one registered read port
// depends on arc_pkg for the entry record

module arc_table #(
  parameter  int TABLE_DEPTH = arc_pkg::DEPTH_DEFAULT,
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  arc_pkg::entry_t      wr_data,
  input  logic [IDX_W-1:0]     rd_addr,
  output arc_pkg::entry_t      rd_data
);

  arc_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/arc_ctrl.sv
// arc_ctrl: sequencer of the cache; walks the table with one shared ip comparator
// and then applies the update and builds the result; depends on arc_pkg

module arc_ctrl #(
  parameter  int TABLE_DEPTH = arc_pkg::DEPTH_DEFAULT,
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  arc_pkg::cmd_t        in_cmd,
  input  arc_pkg::in_item_t    in_item,
  input  arc_pkg::cfg_t        cfg,
  input  logic                 out_free,
  output logic                 res_load,
  output arc_pkg::res_t        res,
  output logic                 tbl_wr_en,
  output logic [IDX_W-1:0]     tbl_wr_addr,
  output arc_pkg::entry_t      tbl_wr_data,
  output logic [IDX_W-1:0]     tbl_rd_addr,
  input  arc_pkg::entry_t      tbl_rd_data,
  output logic [COUNT_W-1:0]   entry_count
);

  arc_pkg::state_t   state_r, state_nxt;
  arc_pkg::cmd_t     cmd_r, cmd_nxt;
  arc_pkg::in_item_t item_r, item_nxt;
  logic [arc_pkg::IP_W-1:0] key_r, key_nxt;
  logic [COUNT_W-1:0] idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   found_idx_r, found_idx_nxt;
  arc_pkg::entry_t    found_ent_r, found_ent_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic match, more, room, ident_ok, for_us;
  logic is_req, is_rep, is_qry;
  logic act_res, act_wr, act_inc, go;
  arc_pkg::res_t       act_out;
  logic [IDX_W-1:0]    act_addr;
  arc_pkg::entry_t     act_data;

  // the shared comparator: stored ip against the search key
  assign match = pend_r && (tbl_rd_data.ip == key_r);
  assign more  = idx_r < count_r;
  assign room  = count_r < COUNT_W'(TABLE_DEPTH);

  assign ident_ok = item_r.arp_ident == cfg.protocol_id;
  assign for_us   = item_r.target_ip == cfg.own_ip;
  assign is_req   = (cmd_r == arc_pkg::CMD_PACKET) && ident_ok &&
                    (item_r.arp_op == arc_pkg::OP_REQUEST);
  assign is_rep   = (cmd_r == arc_pkg::CMD_PACKET) && ident_ok &&
                    (item_r.arp_op == arc_pkg::OP_REPLY);
  assign is_qry   = cmd_r == arc_pkg::CMD_QUERY;

  // update and result once the search is over
  always_comb begin
    act_res  = 1'b0;
    act_wr   = 1'b0;
    act_inc  = 1'b0;
    act_out  = '0;
    act_addr = found_idx_r;
    act_data = found_ent_r;
    if (is_req) begin
      if (found_r) begin
        act_wr            = 1'b1;
        act_data.resolved = 1'b1;
        act_data.mac      = item_r.sender_mac;
      end else if (room) begin
        act_wr            = 1'b1;
        act_inc           = 1'b1;
        act_addr          = count_r[IDX_W-1:0];
        act_data.ip       = item_r.sender_ip;
        act_data.mac      = item_r.sender_mac;
        act_data.hw_kind  = item_r.hw_type;
        act_data.resolved = 1'b1;
        act_data.waiting  = 1'b0;
        act_data.client   = '0;
      end
      if (for_us) begin
        act_res                     = 1'b1;
        act_out.kind                = arc_pkg::KIND_REPLY;
        act_out.item.peer_ip        = item_r.sender_ip;
        act_out.item.peer_mac       = item_r.sender_mac;
        act_out.item.peer_if_index  = cfg.own_if_index;
      end else if (!found_r && !room) begin
        act_res              = 1'b1;
        act_out.kind         = arc_pkg::KIND_FULL;
        act_out.item.peer_ip = item_r.sender_ip;
      end
    end else if (is_rep) begin
      if (found_r) begin
        act_wr            = 1'b1;
        act_data.resolved = 1'b1;
        act_data.hw_kind  = item_r.hw_type;
        act_data.mac      = item_r.sender_mac;
        act_data.waiting  = 1'b0;
        if (found_ent_r.waiting) begin
          act_res                    = 1'b1;
          act_out.kind               = arc_pkg::KIND_WAIT;
          act_out.item.client_id     = found_ent_r.client;
          act_out.item.peer_ip       = found_ent_r.ip;
          act_out.item.peer_mac      = item_r.sender_mac;
          act_out.item.peer_hw_type  = item_r.hw_type;
          act_out.item.peer_if_index = cfg.own_if_index;
        end
      end
    end else if (is_qry) begin
      act_res                = 1'b1;
      act_out.item.client_id = item_r.requester_id;
      if (found_r && found_ent_r.resolved) begin
        act_out.kind               = arc_pkg::KIND_HIT;
        act_out.item.peer_ip       = found_ent_r.ip;
        act_out.item.peer_mac      = found_ent_r.mac;
        act_out.item.peer_hw_type  = found_ent_r.hw_kind;
        act_out.item.peer_if_index = cfg.own_if_index;
      end else if (!found_r && !room) begin
        act_out.kind         = arc_pkg::KIND_FULL;
        act_out.item.peer_ip = item_r.query_ip;
      end else begin
        act_out.kind               = arc_pkg::KIND_BCAST;
        act_out.item.peer_ip       = item_r.query_ip;
        act_out.item.peer_mac      = arc_pkg::MAC_BCAST;
        act_out.item.peer_if_index = cfg.own_if_index;
        act_wr                     = 1'b1;
        act_data.waiting           = 1'b1;
        act_data.client            = item_r.requester_id;
        if (!found_r) begin
          act_inc           = 1'b1;
          act_addr          = count_r[IDX_W-1:0];
          act_data.ip       = item_r.query_ip;
          act_data.mac      = '0;
          act_data.hw_kind  = arc_pkg::HW_PENDING;
          act_data.resolved = 1'b0;
        end
      end
    end
  end

  // a result waits for a free output register; the write waits with it
  assign go = !act_res || out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = arc_pkg::ST_SEARCH;
      end
      arc_pkg::ST_SEARCH: begin
        if (match || !more) state_nxt = arc_pkg::ST_ACT;
      end
      arc_pkg::ST_ACT: begin
        if (go) state_nxt = arc_pkg::ST_IDLE;
      end
      default: state_nxt = arc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    res_load    = 1'b0;
    tbl_wr_en   = 1'b0;
    unique case (state_r)
      arc_pkg::ST_IDLE:   in_ready = 1'b1;
      arc_pkg::ST_SEARCH: ;
      arc_pkg::ST_ACT: begin
        res_load  = act_res && go;
        tbl_wr_en = act_wr && go;
      end
      default: ;
    endcase
  end

  assign res         = act_out;
  assign tbl_wr_addr = act_addr;
  assign tbl_wr_data = act_data;
  assign tbl_rd_addr = idx_r[IDX_W-1:0];
  assign entry_count = count_r;

  // datapath next values
  always_comb begin
    cmd_nxt       = cmd_r;
    item_nxt      = item_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    found_ent_nxt = found_ent_r;
    count_nxt     = count_r;
    unique case (state_r)
      arc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          item_nxt  = in_item;
          key_nxt   = (in_cmd == arc_pkg::CMD_QUERY) ? in_item.query_ip
                                                     : in_item.sender_ip;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
        end
      end
      arc_pkg::ST_SEARCH: begin
        if (match) begin
          found_nxt     = 1'b1;
          found_idx_nxt = cmp_idx_r;
          found_ent_nxt = tbl_rd_data;
          pend_nxt      = 1'b0;
        end else if (more) begin
          pend_nxt    = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + COUNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end
      arc_pkg::ST_ACT: begin
        if (go && act_inc) count_nxt = count_r + COUNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arc_pkg::ST_IDLE;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    item_r      <= item_nxt;
    key_r       <= key_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_idx_r <= found_idx_nxt;
    found_ent_r <= found_ent_nxt;
  end

endmodule

### src/arp_resolution_cache_unit.sv
// arp_resolution_cache_unit: top level of the arp resolution cache
// depends on arc_pkg, arc_table and arc_ctrl

// The cache holds up to TABLE_DEPTH ip-to-mac entries in insertion order and
// takes one word at a time: a received arp packet (tuser 0) or a local resolve
// query (tuser 1). Each word is served by a linear search through the entry
// store, one entry read per cycle into a single shared ip comparator; the
// search covers the filled entries and stops at the first match, and
// in_tready is low while a word is served. A word gives at most one result
// word. The result sits in an output register, so the next input word is
// taken while a result still waits; only a second result finds the register
// full and then holds the sequencer until out_tready. The table needs no
// clearing pass after reset: only entries below the fill count are ever
// read. Configuration is to be written through cfg_wr_en/cfg_addr/cfg_wdata
// only while the block is idle; the block itself does not enforce this.

module arp_resolution_cache_unit #(
  parameter  int TABLE_DEPTH = arc_pkg::DEPTH_DEFAULT,
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  // input words
  input  logic          in_tvalid,
  output logic          in_tready,
  // arp_op, arp_ident, hw_type, sender_ip, sender_mac, target_ip, query_ip,
  // requester_id
  input  logic [199:0]  in_tdata,
  // command
  input  logic [0:0]    in_tuser,
  // result words
  output logic          out_tvalid,
  input  logic          out_tready,
  // client_id, peer_ip, peer_mac, peer_hw_type, peer_if_index
  output logic [111:0]  out_tdata,
  // result_kind
  output logic [2:0]    out_tuser,
  // configuration writes
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_addr,
  input  logic [47:0]   cfg_wdata
);

  // configuration registers
  logic [arc_pkg::IP_W-1:0]  own_ip_r, own_ip_nxt;
  logic [arc_pkg::MAC_W-1:0] own_mac_r, own_mac_nxt;   // held for software, not used in results
  logic [arc_pkg::IF_W-1:0]  own_if_r, own_if_nxt;
  logic [arc_pkg::OP_W-1:0]  proto_id_r, proto_id_nxt;
  arc_pkg::cfg_t             cfg;

  // output register
  logic              out_valid_r, out_valid_nxt;
  arc_pkg::res_t     out_res_r, out_res_nxt;
  logic              out_free;

  // sequencer and table wiring
  logic              res_load;
  arc_pkg::res_t     res;
  logic              tbl_wr_en;
  logic [IDX_W-1:0]  tbl_wr_addr, tbl_rd_addr;
  arc_pkg::entry_t   tbl_wr_data, tbl_rd_data;
  logic [COUNT_W-1:0] entry_count;

  // register writes, one per cycle at most
  always_comb begin
    own_ip_nxt   = own_ip_r;
    own_mac_nxt  = own_mac_r;
    own_if_nxt   = own_if_r;
    proto_id_nxt = proto_id_r;
    if (cfg_wr_en) begin
      unique case (arc_pkg::cfg_reg_t'(cfg_addr))
        arc_pkg::REG_OWN_IP:      own_ip_nxt   = cfg_wdata[arc_pkg::IP_W-1:0];
        arc_pkg::REG_OWN_MAC:     own_mac_nxt  = cfg_wdata[arc_pkg::MAC_W-1:0];
        arc_pkg::REG_OWN_IF:      own_if_nxt   = cfg_wdata[arc_pkg::IF_W-1:0];
        arc_pkg::REG_PROTOCOL_ID: proto_id_nxt = cfg_wdata[arc_pkg::OP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r   <= '0;
      own_mac_r  <= '0;
      own_if_r   <= '0;
      proto_id_r <= '0;
    end else begin
      own_ip_r   <= own_ip_nxt;
      own_mac_r  <= own_mac_nxt;
      own_if_r   <= own_if_nxt;
      proto_id_r <= proto_id_nxt;
    end
  end

  assign cfg.own_ip       = own_ip_r;
  assign cfg.own_if_index = own_if_r;
  assign cfg.protocol_id  = proto_id_r;

  // output register parts the sequencer from the result channel
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.item;
  assign out_tuser  = out_res_r.kind;

  arc_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (arc_pkg::cmd_t'(in_tuser[0])),
    .in_item     (arc_pkg::in_item_t'(in_tdata)),
    .cfg         (cfg),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd_data (tbl_rd_data),
    .entry_count (entry_count)
  );

  arc_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // the table is only written while a word is being worked on
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !tbl_wr_en)
    else $error("table written while idle");

  // a result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

endmodule
